// ===== design/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// apc_pkg
// shared types, constants and table builders for the peak compressor
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int MAX_CHANNELS  = 2;
    localparam int TABLE_ENTRIES = 256;
    localparam int TAB_BITS      = $clog2(TABLE_ENTRIES);
    localparam int TAB_IDX_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [16:0] DB_FLOOR        = -17'sd40960;
    localparam logic [18:0]        DB_PER_LOG2_Q16 = 19'd394566;
    localparam logic signed [15:0] LOG2_PER_DB_Q16 = 16'sd10885;

    // register indexes
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_RATIO     = 3'd1;
    localparam logic [2:0] REG_ATTACK    = 3'd2;
    localparam logic [2:0] REG_RELEASE   = 3'd3;
    localparam logic [2:0] REG_OUT_GAIN  = 3'd4;
    localparam logic [2:0] REG_CHANNELS  = 3'd5;

    typedef logic [16:0] log_tab_t [0:TABLE_ENTRIES];
    typedef logic [31:0] exp_tab_t [0:TABLE_ENTRIES];

    typedef struct packed {
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic [23:0]        peak;
        logic               pass;
        logic               mono;
    } apc_item_t;

    typedef struct packed {
        logic signed [14:0] threshold_db;
        logic [12:0]        ratio_q8;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic signed [14:0] output_gain_db;
    } apc_cfg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ENV_MUL,
        S_ENV_SUM,
        S_LOG_NORM,
        S_LOG_INTERP,
        S_DB_MUL,
        S_DB_CMP,
        S_DIV,
        S_GAIN,
        S_EXP_RD,
        S_EXP_INTERP,
        S_SCALE_L,
        S_SCALE_R,
        S_FIN_R,
        S_OUT
    } apc_state_t;

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned x;
        r = 0;
        b = 64'h1 << 62;
        x = v;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2(1 + i/entries) in Q16
    function automatic log_tab_t calc_log_tab();
        log_tab_t        t;
        longint unsigned x;
        logic [16:0]     r;
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            x = ((64'(TABLE_ENTRIES + i)) << 30) / TABLE_ENTRIES;
            r = '0;
            if (i == TABLE_ENTRIES) begin
                r = 17'd65536;
            end else begin
                for (int b = 15; b >= 0; b--) begin
                    x = (x * x) >> 30;
                    if (x >= (64'h1 << 31)) begin
                        x = x >> 1;
                        r[b] = 1'b1;
                    end
                end
            end
            t[i] = r;
        end
        return t;
    endfunction

    // 2^(i/entries) in Q30
    function automatic exp_tab_t calc_exp_tab();
        exp_tab_t        t;
        longint unsigned roots [0:16];
        longint unsigned f;
        longint unsigned p;
        roots[0] = 64'h1 << 31;
        for (int k = 1; k <= 16; k++) roots[k] = isqrt64(roots[k-1] << 30);
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            f = (64'(i) << 16) / TABLE_ENTRIES;
            p = 64'h1 << 30;
            if (f >= 64'd65536) begin
                p = 64'h1 << 31;
            end else begin
                for (int k = 1; k <= 16; k++)
                    if (((f >> (16 - k)) & 64'd1) != 0) p = (p * roots[k]) >> 30;
            end
            t[i] = p[31:0];
        end
        return t;
    endfunction

endpackage

// ===== design/apc_front.sv =====
// ----------------------------------------------------------------------------
// apc_front
// accepts frames, takes the channel peak and classifies the channel mode
// ----------------------------------------------------------------------------
module apc_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,        // sample_left, sample_right
    input  logic [1:0]         channel_count,
    input  logic               queue_full,
    output logic               push,
    output apc_pkg::apc_item_t item
);
    import apc_pkg::*;

    logic signed [16:0] sx_l, sx_r;
    logic [16:0]        mag_l, mag_r;
    logic [23:0]        pk_l, pk_r;

    always_comb begin
        sx_l  = {s_tdata[15], s_tdata[15:0]};
        sx_r  = {s_tdata[31], s_tdata[31:16]};
        mag_l = sx_l[16] ? 17'(-sx_l) : 17'(sx_l);
        mag_r = sx_r[16] ? 17'(-sx_r) : 17'(sx_r);
        pk_l  = mag_l[16:15] != 2'b00 ? 24'hFFFFFF : {mag_l[14:0], 9'd0};
        pk_r  = mag_r[16:15] != 2'b00 ? 24'hFFFFFF : {mag_r[14:0], 9'd0};

        item.sample_left  = s_tdata[15:0];
        item.sample_right = s_tdata[31:16];
        item.pass         = (channel_count == 2'd0);
        item.mono         = (channel_count == 2'd1) || (MAX_CHANNELS < 2);
        if (item.mono || pk_l >= pk_r) begin
            item.peak = pk_l;
        end else begin
            item.peak = pk_r;
        end
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

endmodule

// ===== design/apc_queue.sv =====
// ----------------------------------------------------------------------------
// apc_queue
// short fifo between the frame front end and the gain sequencer
// ----------------------------------------------------------------------------
module apc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  apc_pkg::apc_item_t push_item,
    input  logic               pop,
    output apc_pkg::apc_item_t pop_item,
    output logic               full,
    output logic               empty
);
    import apc_pkg::*;

    apc_item_t          mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/apc_back.sv =====
// ----------------------------------------------------------------------------
// apc_back
// envelope, dB conversion, gain computer and sample scaling sequencer
// ----------------------------------------------------------------------------
module apc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  apc_pkg::apc_cfg_t  cfg,
    input  logic               queue_empty,
    input  apc_pkg::apc_item_t queue_item,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata         // out_left, out_right, gain_reduction_db
);
    import apc_pkg::*;

    localparam log_tab_t LOG_TAB = calc_log_tab();
    localparam exp_tab_t EXP_TAB = calc_exp_tab();

    apc_state_t state_reg, state_next;

    apc_item_t          item_reg;
    logic [23:0]        env_reg;
    logic [39:0]        pa_reg;
    logic [40:0]        pb_reg;
    logic               zero_reg;
    logic [4:0]         lead_reg;
    logic [16:0]        lb_reg, ld_reg;
    logic [15:0]        lr_reg;
    logic [16:0]        lval_reg;
    logic [39:0]        dbp_reg;
    logic               comp_reg;
    logic [15:0]        d_reg;
    logic [12:0]        rem_reg;
    logic [15:0]        divq_reg;
    logic [2:0]         div_cnt_reg;
    logic signed [16:0] gain_reg;
    logic signed [24:0] l2_reg;
    logic signed [8:0]  ip_reg;
    logic [31:0]        eb_reg, ed_reg;
    logic [15:0]        er_reg;
    logic [31:0]        g_reg;
    logic [48:0]        sc_reg;
    logic [15:0]        ol_reg, or_reg;
    logic               ovalid_reg;
    logic [55:0]        odata_reg;

    // envelope
    logic [15:0] coeff;
    logic [41:0] env_sum;
    // log stage
    logic [4:0]  lead;
    logic [23:0] nrm;
    logic [15:0] frac16;
    logic [TAB_IDX_W-1:0] lidx0, lidx1;
    logic [32:0] lmul;
    logic [20:0] neg;
    // gain computer
    logic signed [16:0] env_db;
    logic signed [17:0] d_full;
    logic [12:0] ratio_eff;
    logic [13:0] r1, r2;
    logic [12:0] rem1, rem2;
    logic        q1, q2;
    logic signed [16:0] gain_c;
    logic signed [17:0] total;
    logic signed [33:0] l2_full;
    // exponent and scaling
    logic [TAB_IDX_W-1:0] eidx0, eidx1;
    logic [47:0] emul;
    logic signed [15:0] s_cur;
    logic signed [16:0] sx;
    logic [16:0] mag;
    logic [15:0] scaled;
    logic        load_out;

    function automatic logic [15:0] shift_sat(logic [48:0] p, logic signed [8:0] ip,
                                              logic neg_s);
        logic signed [9:0] sh;
        logic [48:0]       r;
        logic [15:0]       res;
        sh = 10'sd30 - 10'(ip);
        if (sh < 0) sh = '0;
        r = (sh > 10'sd62) ? '0 : (p >> sh[6:0]);
        if (!neg_s) begin
            res = (r > 49'd32767) ? 16'h7FFF : r[15:0];
        end else begin
            res = (r > 49'd32768) ? 16'h8000 : 16'(~r[15:0] + 16'd1);
        end
        return res;
    endfunction

    always_comb begin
        coeff   = (item_reg.peak > env_reg) ? cfg.attack_coeff : cfg.release_coeff;
        env_sum = 42'(pa_reg) + 42'(pb_reg);

        lead = '0;
        for (int k = 0; k < 24; k++) if (env_reg[k]) lead = 5'(k);
        nrm    = env_reg << (5'd23 - lead);
        frac16 = nrm[22:7];
        lidx0  = TAB_IDX_W'(frac16[15:16-TAB_BITS]);
        lidx1  = lidx0 + 1'b1;
        lmul   = 33'(ld_reg) * 33'(lr_reg);
        neg    = 21'({5'd24 - lead_reg, 16'd0}) - 21'(lval_reg);

        env_db    = zero_reg ? DB_FLOOR : -$signed({1'b0, dbp_reg[39:24]});
        d_full    = 18'(env_db) - 18'(cfg.threshold_db);
        ratio_eff = (cfg.ratio_q8 < 13'd256) ? 13'd256 : cfg.ratio_q8;

        r1   = {rem_reg, divq_reg[15]};
        q1   = (r1 >= {1'b0, ratio_eff});
        rem1 = q1 ? 13'(r1 - {1'b0, ratio_eff}) : r1[12:0];
        r2   = {rem1, divq_reg[14]};
        q2   = (r2 >= {1'b0, ratio_eff});
        rem2 = q2 ? 13'(r2 - {1'b0, ratio_eff}) : r2[12:0];

        gain_c  = comp_reg ? ($signed({1'b0, divq_reg}) - $signed({1'b0, d_reg})) : '0;
        total   = 18'(gain_c) + 18'(cfg.output_gain_db);
        l2_full = $signed(34'(total)) * 34'(LOG2_PER_DB_Q16);

        eidx0 = TAB_IDX_W'(l2_reg[15:16-TAB_BITS]);
        eidx1 = eidx0 + 1'b1;
        emul  = 48'(ed_reg) * 48'(er_reg);

        s_cur  = (state_reg == S_SCALE_L) ? item_reg.sample_left : item_reg.sample_right;
        sx     = {s_cur[15], s_cur};
        mag    = sx[16] ? 17'(-sx) : 17'(sx);
        scaled = shift_sat(sc_reg, ip_reg,
                           (state_reg == S_SCALE_R) ? item_reg.sample_left[15]
                                                    : item_reg.sample_right[15]);
    end

    assign load_out = (state_reg == S_OUT) && (!ovalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (!queue_empty) begin
                    pop        = 1'b1;
                    state_next = queue_item.pass ? S_OUT : S_ENV_MUL;
                end
            end
            S_ENV_MUL:    state_next = S_ENV_SUM;
            S_ENV_SUM:    state_next = S_LOG_NORM;
            S_LOG_NORM:   state_next = S_LOG_INTERP;
            S_LOG_INTERP: state_next = S_DB_MUL;
            S_DB_MUL:     state_next = S_DB_CMP;
            S_DB_CMP:     state_next = S_DIV;
            S_DIV:        if (div_cnt_reg == 3'd7) state_next = S_GAIN;
            S_GAIN:       state_next = S_EXP_RD;
            S_EXP_RD:     state_next = S_EXP_INTERP;
            S_EXP_INTERP: state_next = S_SCALE_L;
            S_SCALE_L:    state_next = S_SCALE_R;
            S_SCALE_R:    state_next = S_FIN_R;
            S_FIN_R:      state_next = S_OUT;
            S_OUT:        if (load_out) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            env_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
            if (state_reg == S_ENV_SUM) env_reg <= env_sum[39:16];
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                item_reg <= queue_item;
                ol_reg   <= queue_item.sample_left;
                or_reg   <= queue_item.sample_right;
                gain_reg <= '0;
            end
            S_ENV_MUL: begin
                pa_reg <= 40'(coeff) * 40'(env_reg);
                pb_reg <= 41'(17'd65536 - 17'(coeff)) * 41'(item_reg.peak);
            end
            S_LOG_NORM: begin
                zero_reg <= (env_reg == '0);
                lead_reg <= lead;
                lb_reg   <= LOG_TAB[lidx0];
                ld_reg   <= LOG_TAB[lidx1] - LOG_TAB[lidx0];
                lr_reg   <= 16'(frac16 << TAB_BITS);
            end
            S_LOG_INTERP: lval_reg <= lb_reg + lmul[32:16];
            S_DB_MUL:     dbp_reg <= 40'(neg) * 40'(DB_PER_LOG2_Q16);
            S_DB_CMP: begin
                comp_reg    <= (env_db > 17'(cfg.threshold_db));
                d_reg       <= d_full[15:0];
                rem_reg     <= {5'd0, d_full[15:8]};
                divq_reg    <= {d_full[7:0], 8'd0};
                div_cnt_reg <= '0;
            end
            S_DIV: begin
                rem_reg     <= rem2;
                divq_reg    <= {divq_reg[13:0], q1, q2};
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            S_GAIN: begin
                gain_reg <= gain_c;
                l2_reg   <= l2_full[32:8];
            end
            S_EXP_RD: begin
                ip_reg <= l2_reg[24:16];
                eb_reg <= EXP_TAB[eidx0];
                ed_reg <= EXP_TAB[eidx1] - EXP_TAB[eidx0];
                er_reg <= 16'(l2_reg[15:0] << TAB_BITS);
            end
            S_EXP_INTERP: g_reg <= eb_reg + emul[47:16];
            S_SCALE_L:    sc_reg <= 49'(mag) * 49'(g_reg);
            S_SCALE_R: begin
                ol_reg <= scaled;
                sc_reg <= 49'(mag) * 49'(g_reg);
            end
            S_FIN_R:      or_reg <= item_reg.mono ? 16'd0 : scaled;
            default: begin
            end
        endcase
        if (load_out) odata_reg <= {7'd0, gain_reg, or_reg, ol_reg};
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    a_gain_nonpos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GAIN) |-> (gain_c[16] || gain_c == '0))
        else $error("compression gain positive");

    a_mono_right: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !item_reg.pass && item_reg.mono) |-> (or_reg == '0))
        else $error("mono frame with nonzero right sample");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < ratio_eff))
        else $error("divider remainder out of range");

endmodule

// ===== design/audio_peak_compressor.sv =====
// ----------------------------------------------------------------------------
// audio_peak_compressor
// feedforward peak compressor, one mono or stereo frame per transaction
// ----------------------------------------------------------------------------
// input stream s_*: one frame per transaction, left sample in the low half
// output stream m_*: scaled left and right samples and the compression gain
// configuration: cfg_wr_en writes cfg_wdata to register cfg_addr; the user
//   writes them only while the block is idle; the block does not enforce it
// a front stage takes the channel peak and parks the frame in a two entry
//   queue; a sequencer runs envelope, log, divide, gain, exponent, scale steps
// a pass-through frame (channel count zero) skips the sequencer steps and
//   goes from idle straight to the output state
// the single sequencer, with its two-bit-per-cycle divider, takes one frame
//   at a time and pops the next frame only when it is back in idle
// reset: envelope cleared, registers at their defaults, queue emptied
// output stall: the finished frame waits in the output register, the
//   sequencer holds, and the queue fills before s_tready drops
// ----------------------------------------------------------------------------
module audio_peak_compressor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_left, sample_right
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_left, out_right, gain_reduction_db
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import apc_pkg::*;

    apc_cfg_t    cfg_reg;
    logic [1:0]  chan_reg;
    apc_item_t   front_item, queue_item;
    logic        push, pop, queue_full, queue_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_db   <= -15'sd4608;
            cfg_reg.ratio_q8       <= 13'd2560;
            cfg_reg.attack_coeff   <= 16'd65308;
            cfg_reg.release_coeff  <= 16'd65513;
            cfg_reg.output_gain_db <= '0;
            chan_reg               <= 2'd2;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_THRESHOLD: cfg_reg.threshold_db   <= cfg_wdata[14:0];
                REG_RATIO:     cfg_reg.ratio_q8       <= cfg_wdata[12:0];
                REG_ATTACK:    cfg_reg.attack_coeff   <= cfg_wdata;
                REG_RELEASE:   cfg_reg.release_coeff  <= cfg_wdata;
                REG_OUT_GAIN:  cfg_reg.output_gain_db <= cfg_wdata[14:0];
                REG_CHANNELS:  chan_reg               <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    apc_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .channel_count (chan_reg),
        .queue_full    (queue_full),
        .push          (push),
        .item          (front_item)
    );

    apc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (queue_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    apc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .queue_item  (queue_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the peak compressor against a cycle-free predictor: envelope, dB
// conversion, gain computer and linear scaling, under random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
    import apc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // sample_left, sample_right
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // out_left, out_right, gain_reduction_db
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    audio_peak_compressor dut (.*);

    typedef struct {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic signed [16:0] gain_red;
    } frame_out_t;

    frame_out_t      expected_frames [$];
    int              mismatches;
    int              hold_cycles;
    int              gap_max;
    int              burst_left;
    bit              done_checking;

    // predictor state
    longint          thr_m;
    longint          ratio_m;
    longint          atk_m;
    longint          rel_m;
    longint          ogain_m;
    longint          chans_m;
    longint unsigned env_m;
    longint unsigned log_t [0:TABLE_ENTRIES];
    longint unsigned exp_t [0:TABLE_ENTRIES];

    initial aclk = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function automatic longint isq(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic build_gain_tables();
        longint unsigned roots [0:16];
        longint unsigned x, f, p, r;
        roots[0] = 64'h1 << 31;
        for (int k = 1; k <= 16; k++) roots[k] = isq(roots[k-1] << 30);
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            x = (64'(TABLE_ENTRIES + i) << 30) / TABLE_ENTRIES;
            r = 0;
            if (i == TABLE_ENTRIES) begin
                r = 65536;
            end else begin
                for (int b = 15; b >= 0; b--) begin
                    x = (x * x) >> 30;
                    if (x >= (64'h1 << 31)) begin
                        x = x >> 1;
                        r = r | (64'h1 << b);
                    end
                end
            end
            log_t[i] = r;
            f = (64'(i) << 16) / TABLE_ENTRIES;
            p = 64'h1 << 30;
            if (f >= 65536) begin
                p = 64'h1 << 31;
            end else begin
                for (int k = 1; k <= 16; k++)
                    if (((f >> (16 - k)) & 1) != 0) p = (p * roots[k]) >> 30;
            end
            exp_t[i] = p;
        end
    endtask

    function automatic longint fshift(longint x, int s);
        if (x >= 0) return x >>> s;
        return -(((-x) + ((64'sd1 << s) - 1)) >>> s);
    endfunction

    function automatic longint level_to_db(longint unsigned e);
        int p;
        longint unsigned fr, pr, ix, rm, lv, ng;
        if (e == 0) return -40960;
        p = 23;
        while (((e >> p) & 1) == 0) p--;
        fr = ((e - (64'h1 << p)) << 16) >> p;
        pr = fr * TABLE_ENTRIES;
        ix = pr >> 16;
        rm = pr & 16'hFFFF;
        lv = log_t[ix] + (((log_t[ix+1] - log_t[ix]) * rm) >> 16);
        ng = longint'(24 - p) * 65536 - lv;
        return -longint'((ng * 394566) >> 24);
    endfunction

    function automatic logic signed [15:0] apply_gain(longint s, longint unsigned g,
                                                      longint ip);
        longint unsigned mag, r;
        longint sh;
        mag = (s < 0) ? -s : s;
        sh = 30 - ip;
        if (sh < 0) sh = 0;
        r = (sh > 62) ? 0 : ((mag * g) >> sh);
        if (s >= 0) return (r > 32767) ? 16'sd32767 : 16'(r);
        return (r > 32768) ? -16'sd32768 : 16'(-longint'(r));
    endfunction

    function automatic frame_out_t compress_frame(logic signed [15:0] sl,
                                                  logic signed [15:0] sr);
        frame_out_t o;
        longint s [2];
        longint unsigned pk, m, cf, g, pr, ix, rm;
        longint nch, edb, gdb, d, rt, tot, l2, ip, fr;
        s[0] = sl;
        s[1] = sr;
        o.out_left = 0;
        o.out_right = 0;
        o.gain_red = 0;
        if (chans_m == 0) begin
            o.out_left = sl;
            o.out_right = sr;
            return o;
        end
        nch = (chans_m > 2) ? 2 : chans_m;
        pk = 0;
        for (int c = 0; c < nch; c++) begin
            m = ((s[c] < 0) ? -s[c] : s[c]) << 9;
            if (m > 24'hFFFFFF) m = 24'hFFFFFF;
            if (m > pk) pk = m;
        end
        cf = (pk > env_m) ? atk_m : rel_m;
        env_m = ((cf * env_m + (65536 - cf) * pk) >> 16) & 24'hFFFFFF;
        edb = level_to_db(env_m);
        gdb = 0;
        if (edb > thr_m) begin
            d = edb - thr_m;
            rt = (ratio_m < 256) ? 256 : ratio_m;
            gdb = ((d * 256) / rt) - d;
        end
        tot = gdb + ogain_m;
        l2 = fshift(tot * 10885, 8);
        ip = fshift(l2, 16);
        fr = l2 - ip * 65536;
        pr = fr * TABLE_ENTRIES;
        ix = pr >> 16;
        rm = pr & 16'hFFFF;
        g = exp_t[ix] + (((exp_t[ix+1] - exp_t[ix]) * rm) >> 16);
        o.out_left = apply_gain(s[0], g, ip);
        if (nch > 1) o.out_right = apply_gain(s[1], g, ip);
        o.gain_red = 17'(gdb);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("error: %s got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // result checker
    always @(posedge aclk) begin
        frame_out_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                w = expected_frames.pop_front();
                if ($signed(m_tdata[15:0]) != w.out_left)
                    report_mismatch("out_left", $signed(m_tdata[15:0]), w.out_left);
                if ($signed(m_tdata[31:16]) != w.out_right)
                    report_mismatch("out_right", $signed(m_tdata[31:16]), w.out_right);
                if ($signed(m_tdata[48:32]) != w.gain_red)
                    report_mismatch("gain_reduction_db", $signed(m_tdata[48:32]),
                                    w.gain_red);
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (done_checking) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0) || (($time / 2000) % 3 == 0);
        end
    end

    task automatic send_frame(logic signed [15:0] sl, logic signed [15:0] sr);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {sr, sl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_frames.push_back(compress_frame(sl, sr));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= 16'(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_m = $signed(15'(v));
            REG_RATIO:     ratio_m = v & 64'h1FFF;
            REG_ATTACK:    atk_m = v & 64'hFFFF;
            REG_RELEASE:   rel_m = v & 64'hFFFF;
            REG_OUT_GAIN:  ogain_m = $signed(15'(v));
            REG_CHANNELS:  chans_m = v & 64'h3;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_random(int n, bit loud);
        logic signed [15:0] a, b;
        for (int i = 0; i < n; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            if (!loud && $urandom_range(0, 1)) begin
                a = a >>> $urandom_range(0, 14);
                b = b >>> $urandom_range(0, 14);
            end
            send_frame(a, b);
        end
    endtask

    task automatic test_extremes();
        send_frame(16'sh7FFF, -16'sh8000);
        send_frame(-16'sh8000, 16'sh7FFF);
        send_frame(0, 0);
        send_frame(16'sh0001, -16'sh0001);
        send_frame(-16'sh8000, -16'sh8000);
        send_frame(16'sh5555, 16'shAAAA);
        for (int i = 0; i < 6; i++) send_frame(16'sh7FFF, 16'sh7FFF);
        for (int i = 0; i < 4; i++) send_frame(16'sh0010, 0);
        drain();
    endtask

    task automatic test_channel_modes();
        for (int c = 0; c < 4; c++) begin
            write_reg(REG_CHANNELS, c);
            send_random(40, 0);
            drain();
        end
        write_reg(REG_CHANNELS, 2);
    endtask

    task automatic test_settings();
        // threshold, ratio, attack, release, makeup gain
        longint sets [6][5] = '{
            '{0, 5120, 0, 0, 6144},
            '{-15360, 256, 65535, 65535, -15360},
            '{-1024, 0, 30000, 65000, 3000},
            '{16383, 8191, 1000, 100, 0},
            '{-3000, 1024, 65535, 0, 16383},
            '{-8000, 3000, 50000, 60000, -16384}};
        for (int k = 0; k < 6; k++) begin
            write_reg(REG_THRESHOLD, sets[k][0]);
            write_reg(REG_RATIO, sets[k][1]);
            write_reg(REG_ATTACK, sets[k][2]);
            write_reg(REG_RELEASE, sets[k][3]);
            write_reg(REG_OUT_GAIN, sets[k][4]);
            write_reg(REG_CHANNELS, $urandom_range(1, 2));
            send_random(150, k[0]);
            drain();
        end
    endtask

    task automatic test_random_config();
        for (int k = 0; k < 5; k++) begin
            write_reg(REG_THRESHOLD, $urandom);
            write_reg(REG_RATIO, $urandom);
            write_reg(REG_ATTACK, $urandom_range(40000, 65535));
            write_reg(REG_RELEASE, $urandom_range(50000, 65535));
            write_reg(REG_OUT_GAIN, $urandom_range(0, 8000) - 4000);
            write_reg(REG_CHANNELS, $urandom_range(0, 3));
            gap_max = (k == 2) ? 0 : $urandom_range(0, 30);
            send_random(100, $urandom_range(0, 1));
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_CHANNELS, 2);
        gap_max = 0;
        hold_cycles <= 400;
        send_random(30, 1);
        drain();
        gap_max = 8;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_THRESHOLD;
        cfg_wdata = '0;
        mismatches = 0;
        hold_cycles = 0;
        gap_max = 8;
        burst_left = 0;
        done_checking = 0;
        thr_m = -4608;
        ratio_m = 2560;
        atk_m = 65308;
        rel_m = 65513;
        ogain_m = 0;
        chans_m = 2;
        env_m = 0;
        build_gain_tables();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_channel_modes();
        test_settings();
        test_random_config();
        test_backpressure();
        done_checking = 1;
        drain();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
